### sv/caf_pkg.sv
// Shared types and command codes for the eight-bit ALU with flags.
package caf_pkg;

   // Operation codes, numbered in issue order
   typedef enum logic [5:0] {
      CMD_ADD   = 6'd0,
      CMD_ADC   = 6'd1,
      CMD_SUB   = 6'd2,
      CMD_SBC   = 6'd3,
      CMD_AND   = 6'd4,
      CMD_XOR   = 6'd5,
      CMD_OR    = 6'd6,
      CMD_CP    = 6'd7,
      CMD_INC   = 6'd8,
      CMD_DEC   = 6'd9,
      CMD_DAA   = 6'd10,
      CMD_CPL   = 6'd11,
      CMD_CCF   = 6'd12,
      CMD_SCF   = 6'd13,
      CMD_RLCA  = 6'd14,
      CMD_RLA   = 6'd15,
      CMD_RRCA  = 6'd16,
      CMD_RRA   = 6'd17,
      CMD_RLC   = 6'd18,
      CMD_RL    = 6'd19,
      CMD_RRC   = 6'd20,
      CMD_RR    = 6'd21,
      CMD_SLA   = 6'd22,
      CMD_SRA   = 6'd23,
      CMD_SRL   = 6'd24,
      CMD_SWAP  = 6'd25,
      CMD_BIT   = 6'd26,
      CMD_SET   = 6'd27,
      CMD_RES   = 6'd28,
      CMD_ADD16 = 6'd29,
      CMD_ADDSP = 6'd30,
      CMD_INC16 = 6'd31,
      CMD_DEC16 = 6'd32
   } command_type;

   // Flag bit positions within the four-bit flag word
   localparam int unsigned FLAG_Z = 3;
   localparam int unsigned FLAG_N = 2;
   localparam int unsigned FLAG_H = 1;
   localparam int unsigned FLAG_C = 0;

   // Decimal adjust constants
   localparam logic [7:0] DAA_LOW_ADJ  = 8'h06;
   localparam logic [7:0] DAA_HIGH_ADJ = 8'h60;
   localparam logic [8:0] DAA_HIGH_LIM = 9'h09F;
   localparam logic [3:0] DAA_LOW_LIM  = 4'd9;

   // One operation as it enters the ALU
   typedef struct packed {
      logic [5:0]  command;
      logic [15:0] first_operand;
      logic [15:0] second_operand;
      logic [2:0]  bit_index;
      logic [3:0]  flags_in;
   } request_type;

   // One computed result
   typedef struct packed {
      logic [15:0] result;
      logic [3:0]  flags_out;
      logic        writes_back;
   } response_type;

endpackage

### sv/caf_core.sv
// Combinational ALU datapath: computes result, flags and write-back mark.
module caf_core
   import caf_pkg::*;
(
   input  request_type  req,
   output response_type rsp
);

   logic [7:0]  a;
   logic [7:0]  v;
   logic [15:0] w1;
   logic [15:0] w2;
   logic        zf;
   logic        nf;
   logic        hf;
   logic        cf;
   logic        wb;
   logic [15:0] res;
   logic [8:0]  sum9;
   logic [4:0]  nib5;
   logic [8:0]  sub_s;
   logic [8:0]  daa1;
   logic [8:0]  daa2;
   logic [7:0]  daa_sub;
   logic [7:0]  byte_res;
   logic [7:0]  rot_src;
   logic [7:0]  bit_mask;
   logic [16:0] sum17;
   logic [12:0] sum13;
   logic        carry_in;

   assign a  = req.first_operand[7:0];
   assign v  = req.second_operand[7:0];
   assign w1 = req.first_operand;
   assign w2 = req.second_operand;

   // Decode and compute one operation
   always_comb begin
      zf       = req.flags_in[FLAG_Z];
      nf       = req.flags_in[FLAG_N];
      hf       = req.flags_in[FLAG_H];
      cf       = req.flags_in[FLAG_C];
      wb       = 1'b1;
      res      = 16'h0000;
      sum9     = 9'd0;
      nib5     = 5'd0;
      sub_s    = 9'd0;
      daa1     = 9'd0;
      daa2     = 9'd0;
      daa_sub  = 8'd0;
      byte_res = 8'd0;
      rot_src  = 8'd0;
      bit_mask = 8'd1 << req.bit_index;
      sum17    = 17'd0;
      sum13    = 13'd0;
      carry_in = 1'b0;

      case (command_type'(req.command))
         CMD_ADD, CMD_ADC: begin
            carry_in = (req.command == CMD_ADC) ? req.flags_in[FLAG_C] : 1'b0;
            sum9     = {1'b0, a} + {1'b0, v} + {8'd0, carry_in};
            nib5     = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, carry_in};
            hf       = nib5[4];
            cf       = sum9[8];
            byte_res = sum9[7:0];
            res      = {8'h00, byte_res};
            zf       = (byte_res == 8'h00);
            nf       = 1'b0;
         end
         CMD_SUB, CMD_CP: begin
            byte_res = a - v;
            zf       = (byte_res == 8'h00);
            nf       = 1'b1;
            hf       = (a[3:0] < v[3:0]);
            cf       = (a < v);
            if (req.command == CMD_CP) begin
               res = {8'h00, a};
               wb  = 1'b0;
            end else begin
               res = {8'h00, byte_res};
            end
         end
         CMD_SBC: begin
            sub_s    = {1'b0, v} + {8'd0, req.flags_in[FLAG_C]};
            sum9     = {1'b0, a} - sub_s;
            byte_res = sum9[7:0];
            res      = {8'h00, byte_res};
            zf       = (byte_res == 8'h00);
            nf       = 1'b1;
            hf       = (a[3:0] < v[3:0]) || (a[3:0] < sub_s[3:0]) ||
                       ((a[3:0] == v[3:0]) && (v[3:0] == 4'hF) && req.flags_in[FLAG_C]);
            cf       = ({1'b0, a} < sub_s);
         end
         CMD_AND: begin
            byte_res = a & v;
            res = {8'h00, byte_res};
            zf = (byte_res == 8'h00); nf = 1'b0; hf = 1'b1; cf = 1'b0;
         end
         CMD_XOR: begin
            byte_res = a ^ v;
            res = {8'h00, byte_res};
            zf = (byte_res == 8'h00); nf = 1'b0; hf = 1'b0; cf = 1'b0;
         end
         CMD_OR: begin
            byte_res = a | v;
            res = {8'h00, byte_res};
            zf = (byte_res == 8'h00); nf = 1'b0; hf = 1'b0; cf = 1'b0;
         end
         CMD_INC: begin
            byte_res = v + 8'd1;
            res = {8'h00, byte_res};
            zf = (byte_res == 8'h00); nf = 1'b0; hf = (byte_res[3:0] == 4'h0);
         end
         CMD_DEC: begin
            byte_res = v - 8'd1;
            res = {8'h00, byte_res};
            zf = (byte_res == 8'h00); nf = 1'b1; hf = (byte_res[3:0] == 4'hF);
         end
         CMD_DAA: begin
            if (!req.flags_in[FLAG_N]) begin
               // adjust after addition: low then high correction
               daa1 = {1'b0, a};
               if (req.flags_in[FLAG_H] || (a[3:0] > DAA_LOW_LIM)) begin
                  daa1 = daa1 + {1'b0, DAA_LOW_ADJ};
               end
               daa2 = daa1;
               if (req.flags_in[FLAG_C] || (daa1 > DAA_HIGH_LIM)) begin
                  daa2 = daa1 + {1'b0, DAA_HIGH_ADJ};
               end
               if (daa2[8]) begin
                  cf = 1'b1;
               end
               byte_res = daa2[7:0];
            end else begin
               // adjust after subtraction: carry is kept
               daa_sub = a;
               if (req.flags_in[FLAG_H]) begin
                  daa_sub = daa_sub - DAA_LOW_ADJ;
               end
               if (req.flags_in[FLAG_C]) begin
                  daa_sub = daa_sub - DAA_HIGH_ADJ;
               end
               byte_res = daa_sub;
            end
            res = {8'h00, byte_res};
            hf  = 1'b0;
            zf  = (byte_res == 8'h00);
         end
         CMD_CPL: begin
            res = {8'h00, ~a}; nf = 1'b1; hf = 1'b1;
         end
         CMD_CCF: begin
            res = {8'h00, a}; nf = 1'b0; hf = 1'b0; cf = ~req.flags_in[FLAG_C];
         end
         CMD_SCF: begin
            res = {8'h00, a}; nf = 1'b0; hf = 1'b0; cf = 1'b1;
         end
         CMD_RLCA, CMD_RLC: begin
            rot_src  = (req.command == CMD_RLCA) ? a : v;
            byte_res = {rot_src[6:0], rot_src[7]};
            cf = rot_src[7];
            res = {8'h00, byte_res};
            zf = (req.command == CMD_RLCA) ? 1'b0 : (byte_res == 8'h00);
            nf = 1'b0; hf = 1'b0;
         end
         CMD_RLA, CMD_RL: begin
            rot_src  = (req.command == CMD_RLA) ? a : v;
            byte_res = {rot_src[6:0], req.flags_in[FLAG_C]};
            cf = rot_src[7];
            res = {8'h00, byte_res};
            zf = (req.command == CMD_RLA) ? 1'b0 : (byte_res == 8'h00);
            nf = 1'b0; hf = 1'b0;
         end
         CMD_RRCA, CMD_RRC: begin
            rot_src  = (req.command == CMD_RRCA) ? a : v;
            byte_res = {rot_src[0], rot_src[7:1]};
            cf = rot_src[0];
            res = {8'h00, byte_res};
            zf = (req.command == CMD_RRCA) ? 1'b0 : (byte_res == 8'h00);
            nf = 1'b0; hf = 1'b0;
         end
         CMD_RRA, CMD_RR: begin
            rot_src  = (req.command == CMD_RRA) ? a : v;
            byte_res = {req.flags_in[FLAG_C], rot_src[7:1]};
            cf = rot_src[0];
            res = {8'h00, byte_res};
            zf = (req.command == CMD_RRA) ? 1'b0 : (byte_res == 8'h00);
            nf = 1'b0; hf = 1'b0;
         end
         CMD_SLA: begin
            byte_res = {v[6:0], 1'b0};
            res = {8'h00, byte_res};
            cf = v[7]; zf = (byte_res == 8'h00); nf = 1'b0; hf = 1'b0;
         end
         CMD_SRA: begin
            byte_res = {v[7], v[7:1]};
            res = {8'h00, byte_res};
            cf = v[0]; zf = (byte_res == 8'h00); nf = 1'b0; hf = 1'b0;
         end
         CMD_SRL: begin
            byte_res = {1'b0, v[7:1]};
            res = {8'h00, byte_res};
            cf = v[0]; zf = (byte_res == 8'h00); nf = 1'b0; hf = 1'b0;
         end
         CMD_SWAP: begin
            byte_res = {v[3:0], v[7:4]};
            res = {8'h00, byte_res};
            zf = (byte_res == 8'h00); nf = 1'b0; hf = 1'b0; cf = 1'b0;
         end
         CMD_BIT: begin
            res = {8'h00, v};
            wb  = 1'b0;
            zf  = ~v[req.bit_index];
            nf  = 1'b0;
            hf  = 1'b1;
         end
         CMD_SET: begin
            res = {8'h00, v | bit_mask};
         end
         CMD_RES: begin
            res = {8'h00, v & ~bit_mask};
         end
         CMD_ADD16: begin
            sum17 = {1'b0, w1} + {1'b0, w2};
            sum13 = {1'b0, w1[11:0]} + {1'b0, w2[11:0]};
            nf  = 1'b0;
            hf  = sum13[12];
            cf  = sum17[16];
            res = sum17[15:0];
         end
         CMD_ADDSP: begin
            // flags from unsigned low nibble and low byte sums
            sum9 = {1'b0, w1[7:0]} + {1'b0, v};
            nib5 = {1'b0, w1[3:0]} + {1'b0, v[3:0]};
            zf  = 1'b0;
            nf  = 1'b0;
            hf  = nib5[4];
            cf  = sum9[8];
            res = w1 + {{8{v[7]}}, v};
         end
         CMD_INC16: begin
            res = w1 + 16'd1;
         end
         CMD_DEC16: begin
            res = w1 - 16'd1;
         end
         default: begin
            // unused codes: no result, flags untouched
            res = 16'h0000;
            wb  = 1'b0;
         end
      endcase

      rsp.result      = res;
      rsp.flags_out   = {zf, nf, hf, cf};
      rsp.writes_back = wb;
   end

endmodule

### sv/cpu_alu_with_flags.sv
// Top level of the eight-bit ALU with flags: input register, datapath, result register.
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    command, first/second operand, bit index, flags
//   rsp      out        rsp_valid/stall    result, flags_out, writes_back
//
// Each transaction passes from acceptance to result through the input
// register, the datapath between the two registers, then the result register.
// One transaction is accepted every cycle while the result side keeps taking.
// Reset empties both registers; payload is not cleared.
// A stall on rsp holds the result register; the input register keeps its
// transaction and req_stall rises only when both registers are full.
module cpu_alu_with_flags
   import caf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [5:0]  req_command,
   input  logic [15:0] req_first_operand,
   input  logic [15:0] req_second_operand,
   input  logic [2:0]  req_bit_index,
   input  logic [3:0]  req_flags_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_result,
   output logic [3:0]  rsp_flags_out,
   output logic        rsp_writes_back
);

   logic         in_valid_ff;
   logic         in_valid_in;
   request_type  in_data_ff;
   logic         out_valid_ff;
   logic         out_valid_in;
   response_type out_data_ff;
   response_type core_rsp;
   logic         out_advance;
   logic         in_advance;

   // Stage moves when its downstream is free
   assign out_advance = !out_valid_ff || !rsp_stall;
   assign in_advance  = !in_valid_ff || out_advance;
   assign req_stall   = !in_advance;

   assign in_valid_in  = in_advance ? req_valid : in_valid_ff;
   assign out_valid_in = out_advance ? in_valid_ff : out_valid_ff;

   // Hold the accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_advance && req_valid) begin
         in_data_ff <= '{command:        req_command,
                         first_operand:  req_first_operand,
                         second_operand: req_second_operand,
                         bit_index:      req_bit_index,
                         flags_in:       req_flags_in};
      end
   end

   // Compute between the registers
   caf_core u_core (
      .req (in_data_ff),
      .rsp (core_rsp)
   );

   // Advance the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_advance && in_valid_ff) begin
         out_data_ff <= core_rsp;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_result      = out_data_ff.result;
   assign rsp_flags_out   = out_data_ff.flags_out;
   assign rsp_writes_back = out_data_ff.writes_back;

   // Never overwrite the held transaction while both registers are blocked
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && out_valid_ff && rsp_stall |-> req_stall)
      else $error("input taken while both stages blocked");

   // Stall only with a held transaction
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("stall raised with empty input register");

   // A held transaction reaches the result register once it moves
   a_moves_on: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && out_advance |=> out_valid_ff)
      else $error("transaction lost between stages");

   // Unused codes never write back
   a_unused_no_wb: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && out_advance && (in_data_ff.command > CMD_DEC16)
      |=> !rsp_writes_back && (rsp_result == 16'h0000))
      else $error("unused command produced a write-back");

endmodule

### bench/cpu_alu_with_flags_checker.sv
// Checker for the eight-bit ALU: watches both channels, predicts each result and compares.
`timescale 1ns / 100ps

module cpu_alu_with_flags_checker
   import caf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [5:0]  req_command,
   input  logic [15:0] req_first_operand,
   input  logic [15:0] req_second_operand,
   input  logic [2:0]  req_bit_index,
   input  logic [3:0]  req_flags_in,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [15:0] rsp_result,
   input  logic [3:0]  rsp_flags_out,
   input  logic        rsp_writes_back,
   output int          error_count,
   output int          outstanding
);

   // Decimal adjust thresholds and steps
   localparam logic [3:0] BCD_DIGIT_MAX = 4'd9;
   localparam logic [8:0] BCD_BYTE_MAX  = 9'h09F;
   localparam logic [8:0] BCD_LOW_STEP  = 9'h006;
   localparam logic [8:0] BCD_HIGH_STEP = 9'h060;

   response_type alu_results[$];

   initial begin
      error_count = 0;
      outstanding = 0;
   end

   // Work out result, flags and write-back mark of one operation
   function automatic response_type alu_outcome(input logic [5:0] op,
         input logic [15:0] word_a, input logic [15:0] word_b,
         input logic [2:0] idx, input logic [3:0] flags);
      logic        z, n, h, c, carry_in, wr, wide;
      logic [7:0]  acc, opd, src, r8;
      logic [15:0] r16;
      logic [4:0]  nib;
      logic [8:0]  sum9;
      logic [12:0] sum13;
      logic [16:0] sum17;
      response_type outcome;
      z = flags[FLAG_Z];
      n = flags[FLAG_N];
      h = flags[FLAG_H];
      c = flags[FLAG_C];
      acc = word_a[7:0];
      opd = word_b[7:0];
      r8 = 8'h00;
      r16 = 16'h0000;
      wr = 1'b1;
      wide = 1'b0;
      // short rotates work on A, the prefixed ones on the operand byte
      src = (op == CMD_RLCA || op == CMD_RLA || op == CMD_RRCA || op == CMD_RRA) ? acc : opd;
      case (op)
         CMD_ADD, CMD_ADC: begin
            carry_in = (op == CMD_ADC) & c;
            nib = {1'b0, acc[3:0]} + {1'b0, opd[3:0]} + {4'h0, carry_in};
            sum9 = {1'b0, acc} + {1'b0, opd} + {8'h00, carry_in};
            r8 = sum9[7:0];
            z = (r8 == 8'h00);
            n = 1'b0;
            h = nib[4];
            c = sum9[8];
         end
         CMD_SUB, CMD_CP: begin
            r8 = acc - opd;
            z = (r8 == 8'h00);
            n = 1'b1;
            h = (acc[3:0] < opd[3:0]);
            c = (acc < opd);
            if (op == CMD_CP) begin
               r8 = acc;
               wr = 1'b0;
            end
         end
         CMD_SBC: begin
            // subtrahend with borrow may reach 0x100
            sum9 = {1'b0, opd} + {8'h00, c};
            r8 = acc - sum9[7:0];
            z = (r8 == 8'h00);
            n = 1'b1;
            h = (acc[3:0] < opd[3:0]) || (acc[3:0] < sum9[3:0]) ||
                ((acc[3:0] == opd[3:0]) && (opd[3:0] == 4'hF) && c);
            c = ({1'b0, acc} < sum9);
         end
         CMD_AND: begin
            r8 = acc & opd;
            z = (r8 == 8'h00);
            {n, h, c} = 3'b010;
         end
         CMD_XOR: begin
            r8 = acc ^ opd;
            z = (r8 == 8'h00);
            {n, h, c} = 3'b000;
         end
         CMD_OR: begin
            r8 = acc | opd;
            z = (r8 == 8'h00);
            {n, h, c} = 3'b000;
         end
         CMD_INC: begin
            r8 = opd + 8'h01;
            z = (r8 == 8'h00);
            n = 1'b0;
            h = (r8[3:0] == 4'h0);
         end
         CMD_DEC: begin
            r8 = opd - 8'h01;
            z = (r8 == 8'h00);
            n = 1'b1;
            h = (r8[3:0] == 4'hF);
         end
         CMD_DAA: begin
            sum9 = {1'b0, acc};
            if (!n) begin
               if (h || sum9[3:0] > BCD_DIGIT_MAX) sum9 = sum9 + BCD_LOW_STEP;
               if (c || sum9 > BCD_BYTE_MAX) sum9 = sum9 + BCD_HIGH_STEP;
               if (sum9[8]) c = 1'b1;
            end else begin
               if (h) sum9[7:0] = sum9[7:0] - BCD_LOW_STEP[7:0];
               if (c) sum9[7:0] = sum9[7:0] - BCD_HIGH_STEP[7:0];
            end
            r8 = sum9[7:0];
            h = 1'b0;
            z = (r8 == 8'h00);
         end
         CMD_CPL: begin
            r8 = ~acc;
            {n, h} = 2'b11;
         end
         CMD_CCF: begin
            r8 = acc;
            {n, h} = 2'b00;
            c = ~c;
         end
         CMD_SCF: begin
            r8 = acc;
            {n, h, c} = 3'b001;
         end
         CMD_RLCA, CMD_RLC: begin
            r8 = {src[6:0], src[7]};
            c = src[7];
            z = (op == CMD_RLC) && (r8 == 8'h00);
            {n, h} = 2'b00;
         end
         CMD_RLA, CMD_RL: begin
            r8 = {src[6:0], c};
            c = src[7];
            z = (op == CMD_RL) && (r8 == 8'h00);
            {n, h} = 2'b00;
         end
         CMD_RRCA, CMD_RRC: begin
            r8 = {src[0], src[7:1]};
            c = src[0];
            z = (op == CMD_RRC) && (r8 == 8'h00);
            {n, h} = 2'b00;
         end
         CMD_RRA, CMD_RR: begin
            r8 = {c, src[7:1]};
            c = src[0];
            z = (op == CMD_RR) && (r8 == 8'h00);
            {n, h} = 2'b00;
         end
         CMD_SLA: begin
            r8 = {opd[6:0], 1'b0};
            c = opd[7];
            z = (r8 == 8'h00);
            {n, h} = 2'b00;
         end
         CMD_SRA: begin
            r8 = {opd[7], opd[7:1]};
            c = opd[0];
            z = (r8 == 8'h00);
            {n, h} = 2'b00;
         end
         CMD_SRL: begin
            r8 = {1'b0, opd[7:1]};
            c = opd[0];
            z = (r8 == 8'h00);
            {n, h} = 2'b00;
         end
         CMD_SWAP: begin
            r8 = {opd[3:0], opd[7:4]};
            z = (r8 == 8'h00);
            {n, h, c} = 3'b000;
         end
         CMD_BIT: begin
            r8 = opd;
            wr = 1'b0;
            z = ~opd[idx];
            {n, h} = 2'b01;
         end
         CMD_SET: r8 = opd | (8'h01 << idx);
         CMD_RES: r8 = opd & ~(8'h01 << idx);
         CMD_ADD16: begin
            wide = 1'b1;
            sum13 = {1'b0, word_a[11:0]} + {1'b0, word_b[11:0]};
            sum17 = {1'b0, word_a} + {1'b0, word_b};
            r16 = sum17[15:0];
            n = 1'b0;
            h = sum13[12];
            c = sum17[16];
         end
         CMD_ADDSP: begin
            // flags from the unsigned low byte, value from the signed offset
            wide = 1'b1;
            nib = {1'b0, word_a[3:0]} + {1'b0, opd[3:0]};
            sum9 = {1'b0, word_a[7:0]} + {1'b0, opd};
            r16 = word_a + {{8{opd[7]}}, opd};
            {z, n} = 2'b00;
            h = nib[4];
            c = sum9[8];
         end
         CMD_INC16: begin
            wide = 1'b1;
            r16 = word_a + 16'h0001;
         end
         CMD_DEC16: begin
            wide = 1'b1;
            r16 = word_a - 16'h0001;
         end
         default: begin
            r8 = 8'h00;
            wr = 1'b0;
         end
      endcase
      outcome.result = wide ? r16 : {8'h00, r8};
      outcome.flags_out[FLAG_Z] = z;
      outcome.flags_out[FLAG_N] = n;
      outcome.flags_out[FLAG_H] = h;
      outcome.flags_out[FLAG_C] = c;
      outcome.writes_back = wr;
      return outcome;
   endfunction

   // Report one differing field
   function automatic void compare_field(input string label, input logic [15:0] want,
         input logic [15:0] got);
      if (want !== got) begin
         error_count++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
      end
   endfunction

   // Retire results before recording new operations on each edge
   always @(posedge clock) begin
      response_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (alu_results.size() == 0) begin
               error_count++;
               $display("%0t: result transaction with nothing expected, expected none, actual %h",
                        $time, rsp_result);
            end else begin
               want = alu_results.pop_front();
               compare_field("result", want.result, rsp_result);
               compare_field("flags_out", {12'h000, want.flags_out}, {12'h000, rsp_flags_out});
               compare_field("writes_back", {15'h0000, want.writes_back},
                             {15'h0000, rsp_writes_back});
            end
         end
         if (req_valid && !req_stall)
            alu_results.push_back(alu_outcome(req_command, req_first_operand,
                                              req_second_operand, req_bit_index, req_flags_in));
         outstanding = alu_results.size();
      end
   end

endmodule

### bench/cpu_alu_with_flags_tb.sv
// Top of the ALU testbench: clock, reset, operation stimulus, result-side stalls and verdict.
`timescale 1ns / 100ps

module cpu_alu_with_flags_tb
   import caf_pkg::*;
();

   localparam int          RANDOM_OPS     = 1615;
   localparam int          CYCLE_LIMIT    = 200000;
   localparam int          HOLD_CYCLES    = 120;
   localparam int          HOLD_INTERVAL  = 2500;
   localparam int          DRAIN_CYCLES   = 8;
   localparam logic [5:0]  CMD_FIRST_FREE = CMD_DEC16 + 6'd1;
   localparam logic [5:0]  CMD_CODE_MAX   = 6'h3F;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [5:0]  req_command = CMD_ADD;
   logic [15:0] req_first_operand = 16'h0000;
   logic [15:0] req_second_operand = 16'h0000;
   logic [2:0]  req_bit_index = 3'd0;
   logic [3:0]  req_flags_in = 4'h0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_result;
   logic [3:0]  rsp_flags_out;
   logic        rsp_writes_back;
   int          error_count;
   int          outstanding;
   int          cycle_count = 0;
   int          stall_cycles = 0;

   cpu_alu_with_flags u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command        (req_command),
      .req_first_operand  (req_first_operand),
      .req_second_operand (req_second_operand),
      .req_bit_index      (req_bit_index),
      .req_flags_in       (req_flags_in),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result         (rsp_result),
      .rsp_flags_out      (rsp_flags_out),
      .rsp_writes_back    (rsp_writes_back)
   );

   cpu_alu_with_flags_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command        (req_command),
      .req_first_operand  (req_first_operand),
      .req_second_operand (req_second_operand),
      .req_bit_index      (req_bit_index),
      .req_flags_in       (req_flags_in),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result         (rsp_result),
      .rsp_flags_out      (rsp_flags_out),
      .rsp_writes_back    (rsp_writes_back),
      .error_count        (error_count),
      .outstanding        (outstanding)
   );

   // Free-running clock, 4 ns period
   initial begin
      forever #2 clock = ~clock;
   end

   // Hold reset from the start, then release it once
   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // End the run with an error once the cycle limit is reached
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   // Idle the request side for the given gap, if any, then offer one transaction until taken
   task automatic send_op(input logic [5:0] op, input logic [15:0] word_a,
         input logic [15:0] word_b, input logic [2:0] idx, input logic [3:0] flags,
         input int gap);
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid          <= 1'b1;
      req_command        <= op;
      req_first_operand  <= word_a;
      req_second_operand <= word_b;
      req_bit_index      <= idx;
      req_flags_in       <= flags;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Operand word, biased toward byte and nibble boundaries
   function automatic logic [15:0] pick_word();
      logic [7:0] edge_byte;
      case ($urandom_range(0, 7))
         0: edge_byte = 8'h00;
         1: edge_byte = 8'hFF;
         2: edge_byte = 8'h0F;
         3: edge_byte = 8'h80;
         4: edge_byte = 8'h7F;
         5: edge_byte = 8'h99;
         default: edge_byte = 8'($urandom);
      endcase
      case ($urandom_range(0, 9))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2, 3: return {8'($urandom), edge_byte};
         default: return 16'($urandom);
      endcase
   endfunction

   // Sender gap: mostly none or short, now and then long
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(5, 20);
   endfunction

   // Drive rsp_stall for a number of cycles and keep count
   task automatic hold_stall(input logic level, input int span);
      @(negedge clock);
      rsp_stall <= level;
      repeat (span - 1) @(negedge clock);
      stall_cycles += span;
   endtask

   // Result side: free runs, short and long stalls, and a long hold now and then
   initial begin
      int next_hold;
      int roll;
      next_hold = 300;
      while (reset) @(negedge clock);
      forever begin
         if (stall_cycles >= next_hold) begin
            hold_stall(1'b1, HOLD_CYCLES);
            next_hold += HOLD_INTERVAL;
         end
         roll = $urandom_range(0, 9);
         if (roll < 3)
            hold_stall(1'b0, $urandom_range(10, 60));
         else if (roll < 9) begin
            hold_stall(1'b1, $urandom_range(1, 3));
            hold_stall(1'b0, $urandom_range(1, 4));
         end else begin
            hold_stall(1'b1, $urandom_range(10, 30));
            hold_stall(1'b0, 1);
         end
      end
   end

   // Operation stimulus and verdict
   initial begin
      logic [5:0] op;
      int gap;
      while (reset) @(negedge clock);

      // Every command at least once, plus an unused code, at field extremes and on the named corner cases
      send_op(CMD_ADD,   16'h00FF, 16'hFF01, 3'd0, 4'h0, 0);
      send_op(CMD_ADC,   16'hAB0F, 16'h0000, 3'd0, 4'h1, 0);
      send_op(CMD_SUB,   16'h0010, 16'h0001, 3'd7, 4'hF, 0);
      send_op(CMD_SBC,   16'h000F, 16'h000F, 3'd0, 4'h1, 0);
      send_op(CMD_SBC,   16'h0000, 16'h00FF, 3'd0, 4'h1, 0);
      send_op(CMD_AND,   16'hFFFF, 16'h0000, 3'd0, 4'h0, 0);
      send_op(CMD_XOR,   16'h00FF, 16'hFFFF, 3'd0, 4'h0, 0);
      send_op(CMD_OR,    16'h0000, 16'h0000, 3'd0, 4'hF, 0);
      send_op(CMD_CP,    16'h0042, 16'h0042, 3'd0, 4'h0, 0);
      send_op(CMD_INC,   16'h0000, 16'hFFFF, 3'd0, 4'h1, 0);
      send_op(CMD_DEC,   16'h0000, 16'h0010, 3'd0, 4'h0, 0);
      send_op(CMD_DAA,   16'h009A, 16'h0000, 3'd0, 4'h0, 0);
      send_op(CMD_DAA,   16'h0000, 16'h0000, 3'd0, 4'h7, 0);
      send_op(CMD_CPL,   16'hFF5A, 16'h0000, 3'd0, 4'h0, 0);
      send_op(CMD_CCF,   16'h0033, 16'h0000, 3'd0, 4'h1, 0);
      send_op(CMD_SCF,   16'h0033, 16'h0000, 3'd0, 4'hE, 0);
      send_op(CMD_RLCA,  16'h0080, 16'h0000, 3'd0, 4'h8, 0);
      send_op(CMD_RLA,   16'h0080, 16'h0000, 3'd0, 4'h0, 0);
      send_op(CMD_RRCA,  16'h0001, 16'h0000, 3'd0, 4'h0, 0);
      send_op(CMD_RRA,   16'h0001, 16'h0000, 3'd0, 4'h0, 0);
      send_op(CMD_RLC,   16'h0000, 16'hFF00, 3'd0, 4'h0, 0);
      send_op(CMD_RL,    16'h0000, 16'h0080, 3'd0, 4'h0, 0);
      send_op(CMD_RRC,   16'h0000, 16'h0001, 3'd0, 4'h0, 0);
      send_op(CMD_RR,    16'h0000, 16'h0001, 3'd0, 4'h0, 0);
      send_op(CMD_SLA,   16'h0000, 16'h0080, 3'd0, 4'h0, 0);
      send_op(CMD_SRA,   16'h0000, 16'h0081, 3'd0, 4'h0, 0);
      send_op(CMD_SRL,   16'h0000, 16'h0001, 3'd0, 4'h0, 0);
      send_op(CMD_SWAP,  16'h0000, 16'h00F0, 3'd0, 4'hF, 0);
      send_op(CMD_BIT,   16'h0000, 16'h007F, 3'd7, 4'h1, 0);
      send_op(CMD_SET,   16'h0000, 16'h0000, 3'd7, 4'h0, 0);
      send_op(CMD_RES,   16'h0000, 16'hFFFF, 3'd0, 4'hF, 0);
      send_op(CMD_ADD16, 16'h0FFF, 16'hF001, 3'd0, 4'hF, 0);
      send_op(CMD_ADDSP, 16'hFFF8, 16'h0088, 3'd0, 4'hF, 0);
      send_op(CMD_INC16, 16'hFFFF, 16'h0000, 3'd0, 4'h0, 0);
      send_op(CMD_DEC16, 16'h0000, 16'h0000, 3'd0, 4'h0, 0);
      send_op(CMD_CODE_MAX, 16'hFFFF, 16'hFFFF, 3'd7, 4'hF, 0);

      // Random operations; every fourth stretch runs back to back
      for (int i = 0; i < RANDOM_OPS; i++) begin
         if ($urandom_range(0, 15) == 0)
            op = 6'($urandom_range(CMD_FIRST_FREE, CMD_CODE_MAX));
         else
            op = 6'($urandom_range(CMD_ADD, CMD_DEC16));
         gap = ((i / 80) % 4 == 1) ? 0 : pick_gap();
         send_op(op, pick_word(), pick_word(), 3'($urandom), 4'($urandom), gap);
      end

      // Drop valid, drain, then wait DRAIN_CYCLES for stray results
      @(negedge clock);
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (error_count == 0 && outstanding == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

### sim.f
sv/caf_pkg.sv
sv/caf_core.sv
sv/cpu_alu_with_flags.sv
bench/cpu_alu_with_flags_checker.sv
bench/cpu_alu_with_flags_tb.sv
